// File: src/elt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elt_pkg: shared types and codes for the expiring lock table
// Command, lock type and level codes, and the controller/datapath handshake.
// ----------------------------------------------------------------------------
package elt_pkg;

  localparam int TIME_W = 63;
  localparam int DUR_W  = 64;

  // command codes
  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_EXPIRE = 3'd2;
  localparam logic [2:0] CMD_QUERY  = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // lock types
  localparam logic [2:0] LT_SYMBOL   = 3'd0;
  localparam logic [2:0] LT_STRATEGY = 3'd1;
  localparam logic [2:0] LT_DAY      = 3'd2;
  localparam logic [2:0] LT_ACCOUNT  = 3'd3;
  localparam logic [2:0] LT_HALT     = 3'd4;
  localparam logic [2:0] LT_COOLDOWN = 3'd5;

  // global levels
  localparam logic [2:0] LVL_NORMAL   = 3'd0;
  localparam logic [2:0] LVL_DEGRADED = 3'd1;
  localparam logic [2:0] LVL_DAY      = 3'd2;
  localparam logic [2:0] LVL_ACCOUNT  = 3'd3;
  localparam logic [2:0] LVL_HALT     = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch the input word, clear accumulators
    logic rd_en;   // read entry at scan index, advance index
    logic commit;  // apply pending add, register result
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rd_last; // scan index is on the last entry
  } dp_sts_t;

endpackage

// File: src/elt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module elt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/elt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elt_ctrl: command sequencer
// Walks one command through load, entry scan, drain and commit.
// ----------------------------------------------------------------------------
module elt_ctrl import elt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.rd_en  = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (sts.rd_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;  // last entry evaluated here
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// File: src/elt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elt_dp: lock table datapath
// Entry RAM, valid bits, scan pipeline, accumulators and result registers.
// ----------------------------------------------------------------------------
module elt_dp import elt_pkg::*; #(
  parameter int LOCK_ENTRIES = 16,
  parameter int TARGET_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_cmd_t           cmd,
  output dp_sts_t            sts,
  input  logic [2:0]         in_command,
  input  logic [2:0]         in_lock_type,
  input  logic [15:0]        in_target_id,
  input  logic [TIME_W-1:0]  in_now_time,
  input  logic signed [DUR_W-1:0] in_duration,
  output logic               out_valid,
  output logic               out_locked,
  output logic               out_type_present,
  output logic [2:0]         out_priority_level,
  output logic [4:0]         out_lock_count,
  output logic               out_add_dropped
);

  localparam int IW = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
  localparam int CW = $clog2(LOCK_ENTRIES + 1);
  localparam int RW = 3 + TARGET_BITS + TIME_W + DUR_W;

  // latched word
  logic [2:0]             cmd_r;
  logic [2:0]             type_r;
  logic [TARGET_BITS-1:0] tgt_r;
  logic [TIME_W-1:0]      now_r;
  logic [DUR_W-1:0]       dur_r;

  // scan pipeline
  logic [IW-1:0] rd_idx_r;
  logic          ev_vld_r;
  logic [IW-1:0] ev_idx_r;

  logic [LOCK_ENTRIES-1:0] valid_r;

  // accumulators
  logic          found_r, free_ok_r;
  logic [IW-1:0] free_idx_r;
  logic          locked_r, present_r, halt_r, acct_r, day_r, degr_r;
  logic [CW-1:0] cnt_r;

  // RAM
  logic          ram_we;
  logic [RW-1:0] ram_wdata, ram_rdata;

  // command decode
  logic is_add, is_remove, is_expire, is_clear;
  assign is_add    = (cmd_r == CMD_ADD);
  assign is_remove = (cmd_r == CMD_REMOVE);
  assign is_expire = (cmd_r == CMD_EXPIRE);
  assign is_clear  = (cmd_r == CMD_CLEAR);

  // entry fields
  logic [2:0]              e_type;
  logic [TARGET_BITS-1:0]  e_tgt;
  logic [TIME_W-1:0]       e_start;
  logic signed [DUR_W-1:0] e_life;
  logic signed [DUR_W-1:0] age;
  logic e_valid, type_eq, match, expired, drop, keep;

  assign e_type  = ram_rdata[RW-1 -: 3];
  assign e_tgt   = ram_rdata[DUR_W+TIME_W +: TARGET_BITS];
  assign e_start = ram_rdata[DUR_W +: TIME_W];
  assign e_life  = ram_rdata[DUR_W-1:0];

  always_comb begin
    e_valid = valid_r[ev_idx_r];
    type_eq = (e_type == type_r);
    match   = e_valid && type_eq && (e_tgt == tgt_r);
    // both times are 63-bit, so the 64-bit difference cannot wrap
    age     = signed'({1'b0, now_r}) - signed'({1'b0, e_start});
    expired = e_valid && !e_life[DUR_W-1] && (|e_life) && (age >= e_life);
    priority if (is_remove) drop = match;
    else if (is_expire)     drop = expired;
    else if (is_clear)      drop = 1'b1;
    else                    drop = 1'b0;
    keep = e_valid && !drop;
  end

  assign sts.rd_last = (rd_idx_r == IW'(LOCK_ENTRIES - 1));

  // input latch and scan index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_command;
      type_r   <= in_lock_type;
      tgt_r    <= TARGET_BITS'(in_target_id);
      now_r    <= in_now_time;
      dur_r    <= in_duration;
      rd_idx_r <= '0;
    end else if (cmd.rd_en) begin
      rd_idx_r <= rd_idx_r + IW'(1);
    end
    ev_idx_r <= rd_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_vld_r <= 1'b0;
    end else begin
      ev_vld_r <= cmd.rd_en;
    end
  end

  // commit-time values
  logic          do_add, dropped;
  logic          halt_f, acct_f, day_f, degr_f;
  logic [CW-1:0] cnt_f;
  logic [2:0]    level_f;

  always_comb begin
    do_add  = is_add && !found_r && free_ok_r;
    dropped = is_add && !found_r && !free_ok_r;
    halt_f  = halt_r || (do_add && type_r == LT_HALT);
    acct_f  = acct_r || (do_add && type_r == LT_ACCOUNT);
    day_f   = day_r  || (do_add && type_r == LT_DAY);
    degr_f  = degr_r || (do_add && (type_r == LT_SYMBOL || type_r == LT_STRATEGY ||
                                    type_r == LT_COOLDOWN));
    cnt_f   = cnt_r + CW'(do_add);
    priority if (halt_f) level_f = LVL_HALT;
    else if (acct_f)     level_f = LVL_ACCOUNT;
    else if (day_f)      level_f = LVL_DAY;
    else if (degr_f)     level_f = LVL_DEGRADED;
    else                 level_f = LVL_NORMAL;
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found_r   <= 1'b0;
      free_ok_r <= 1'b0;
      locked_r  <= 1'b0;
      present_r <= 1'b0;
      halt_r    <= 1'b0;
      acct_r    <= 1'b0;
      day_r     <= 1'b0;
      degr_r    <= 1'b0;
      cnt_r     <= '0;
    end else if (ev_vld_r) begin
      if (match) found_r <= 1'b1;
      if (!e_valid && !free_ok_r) begin
        free_ok_r  <= 1'b1;
        free_idx_r <= ev_idx_r;
      end
      if (keep) begin
        cnt_r <= cnt_r + CW'(1);
        if (type_eq) begin
          present_r <= 1'b1;
          if (e_tgt == tgt_r) locked_r <= 1'b1;
        end
        if (e_type == LT_HALT)    halt_r <= 1'b1;
        if (e_type == LT_ACCOUNT) acct_r <= 1'b1;
        if (e_type == LT_DAY)     day_r  <= 1'b1;
        if (e_type == LT_SYMBOL || e_type == LT_STRATEGY || e_type == LT_COOLDOWN)
          degr_r <= 1'b1;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ev_vld_r && drop) begin
      valid_r[ev_idx_r] <= 1'b0;
    end else if (ram_we) begin
      valid_r[free_idx_r] <= 1'b1;
    end
  end

  assign ram_we    = cmd.commit && do_add;
  assign ram_wdata = {type_r, tgt_r, now_r, dur_r};

  elt_ram #(
    .WIDTH (RW),
    .DEPTH (LOCK_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  // result registers
  logic       out_valid_r, out_locked_r, out_present_r, out_dropped_r;
  logic [2:0] out_level_r;
  logic [4:0] out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_locked_r  <= locked_r || do_add;
      out_present_r <= present_r || do_add;
      out_level_r   <= level_f;
      out_count_r   <= 5'(cnt_f);
      out_dropped_r <= dropped;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_locked         = out_locked_r;
  assign out_type_present   = out_present_r;
  assign out_priority_level = out_level_r;
  assign out_lock_count     = out_count_r;
  assign out_add_dropped    = out_dropped_r;

endmodule

// File: src/expiring_lock_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expiring_lock_table: bounded table of typed, timed locks
// Add / remove / expire / query / clear-all commands with one status word out.
// ----------------------------------------------------------------------------
// A command word is taken when start is high while busy is low. The block then
// scans every table entry through a single RAM read port, one entry per cycle,
// then drains and commits, keeping busy high; out_valid pulses for exactly
// one cycle right after busy drops, and a new word may be started in that same
// cycle. No new word is taken while busy is high. There is no back-pressure
// on the result side: the receiver must take the word in the cycle out_valid
// is high. No clearing pass follows reset; the table is empty as soon as
// rst_n is released.
// ----------------------------------------------------------------------------
module expiring_lock_table import elt_pkg::*; #(
  parameter int LOCK_ENTRIES = 16,
  parameter int TARGET_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // command word
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              in_command,
  input  logic [2:0]              in_lock_type,
  input  logic [15:0]             in_target_id,
  input  logic [TIME_W-1:0]       in_now_time,
  input  logic signed [DUR_W-1:0] in_duration,
  // status word
  output logic                    out_valid,
  output logic                    out_locked,
  output logic                    out_type_present,
  output logic [2:0]              out_priority_level,
  output logic [4:0]              out_lock_count,
  output logic                    out_add_dropped
);

  ctl_cmd_t ctl_cmd;
  dp_sts_t  dp_sts;

  // Sequencer: idle -> scan (one entry per cycle) -> drain -> commit.
  elt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (dp_sts),
    .cmd   (ctl_cmd)
  );

  // Datapath: during the scan, remove/expire/clear drop entries and the
  // surviving entries feed the flags and count; an add lands at commit in
  // the lowest free entry found by the scan.
  elt_dp #(
    .LOCK_ENTRIES (LOCK_ENTRIES),
    .TARGET_BITS  (TARGET_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (ctl_cmd),
    .sts                (dp_sts),
    .in_command         (in_command),
    .in_lock_type       (in_lock_type),
    .in_target_id       (in_target_id),
    .in_now_time        (in_now_time),
    .in_duration        (in_duration),
    .out_valid          (out_valid),
    .out_locked         (out_locked),
    .out_type_present   (out_type_present),
    .out_priority_level (out_priority_level),
    .out_lock_count     (out_lock_count),
    .out_add_dropped    (out_add_dropped)
  );

  // An accepted word always starts a busy period.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // Result strobe only follows a busy cycle.
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding scan");

  // Result strobe is a single-cycle pulse.
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // A refused add means the table was full and the lock was absent.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_add_dropped) |->
      (!out_locked && out_lock_count == 5'(LOCK_ENTRIES)))
    else $error("add dropped with a free entry or existing lock");

endmodule
